[hw/rtl/cdq_pkg.sv]
// Shared constants, codes and types of the circular deque.
package cdq_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int DATA_W    = 32;
	localparam int OP_W      = 3;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 10;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [2:0] {
		KIND_PUSH_FRONT,
		KIND_PUSH_BACK,
		KIND_POP_FRONT,
		KIND_POP_BACK,
		KIND_QUERY
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [DATA_W-1:0] value;
	} cmd_t;

endpackage

[hw/rtl/cdq_ifs.sv]
// Valid/ready channel interfaces for the deque request and result beats.
interface cdq_in_if import cdq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

interface cdq_out_if import cdq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] popped;
	logic [STATUS_W-1:0]      status;
	logic [COUNT_W-1:0]       count;
	logic                     is_empty;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;

	modport source (output valid, output popped, output status, output count,
		output is_empty, output front_value, output back_value, input ready);
	modport sink (input valid, input popped, input status, input count,
		input is_empty, input front_value, input back_value, output ready);
endinterface

[hw/rtl/cdq_front.sv]
// Front end: accepts request beats and classifies the operation code.
module cdq_front import cdq_pkg::*; (
	cdq_in_if.sink cmd,
	output logic   q_valid,
	output cmd_t   q_cmd,
	input  logic   q_ready
);

	kind_t kind;

	// Codes beyond the defined set behave as a query.
	always_comb begin
		case (cmd.op)
			OP_PUSH_FRONT: kind = KIND_PUSH_FRONT;
			OP_PUSH_BACK:  kind = KIND_PUSH_BACK;
			OP_POP_FRONT:  kind = KIND_POP_FRONT;
			OP_POP_BACK:   kind = KIND_POP_BACK;
			default:       kind = KIND_QUERY;
		endcase
	end

	assign q_valid     = cmd.valid;
	assign q_cmd.kind  = kind;
	assign q_cmd.value = cmd.value;
	assign cmd.ready   = q_ready;

endmodule

[hw/rtl/cdq_cmd_q.sv]
// Two-entry command queue between the front end and the execution unit.
module cdq_cmd_q import cdq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  cmd_t in_cmd,
	output logic in_ready,
	output logic out_valid,
	output cmd_t out_cmd,
	input  logic out_ready
);

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign in_ready  = (fill_q != 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign out_cmd   = slot_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_cmd;
		end
	end

endmodule

[hw/rtl/cdq_exec.sv]
// Execution unit: ring memory, head and tail pointers, end caches and result register.
module cdq_exec import cdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_ready,
	cdq_out_if.source  rsp
);

	localparam int PTR_W     = $clog2(DEPTH);
	localparam int CNT_EXT_W = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	localparam logic S_IDLE  = 1'b0;
	localparam logic S_FETCH = 1'b1;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		return (p == '0) ? LAST : p - 1'b1;
	endfunction

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	logic              state_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [PTR_W-1:0]  cnt_q;
	logic [DATA_W-1:0] front_q;
	logic [DATA_W-1:0] back_q;
	logic              fetch_front_q;

	logic                res_valid_q;
	logic [DATA_W-1:0]   res_popped_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [COUNT_W-1:0]  res_count_q;
	logic                res_empty_q;
	logic [DATA_W-1:0]   res_front_q;
	logic [DATA_W-1:0]   res_back_q;

	logic                take;
	logic                was_empty;
	logic                was_full;
	logic                do_write;
	logic                do_read;
	logic [PTR_W-1:0]    wr_addr;
	logic [PTR_W-1:0]    rd_addr;
	logic [PTR_W-1:0]    head_n;
	logic [PTR_W-1:0]    tail_n;
	logic [PTR_W-1:0]    cnt_n;
	logic [DATA_W-1:0]   front_n;
	logic [DATA_W-1:0]   back_n;
	logic [DATA_W-1:0]   popped_n;
	logic [STATUS_W-1:0] status_n;
	logic                empty_n;
	logic [CNT_EXT_W-1:0] cnt_ext;

	assign cmd_ready = (state_q == S_IDLE) && (!res_valid_q || rsp.ready);
	assign take      = cmd_ready && cmd_valid;
	assign was_empty = (cnt_q == '0);
	assign was_full  = (cnt_q == LAST);

	always_comb begin
		do_write = 1'b0;
		do_read  = 1'b0;
		wr_addr  = head_q;
		rd_addr  = tail_q;
		head_n   = head_q;
		tail_n   = tail_q;
		cnt_n    = cnt_q;
		front_n  = front_q;
		back_n   = back_q;
		popped_n = '0;
		status_n = STATUS_OK;
		case (cmd.kind)
			KIND_PUSH_FRONT: begin
				if (was_full) begin
					status_n = STATUS_FULL;
				end else begin
					do_write = 1'b1;
					wr_addr  = head_q;
					head_n   = ptr_dec(head_q);
					cnt_n    = cnt_q + 1'b1;
					front_n  = cmd.value;
					if (was_empty) begin
						back_n = cmd.value;
					end
				end
			end
			KIND_PUSH_BACK: begin
				if (was_full) begin
					status_n = STATUS_FULL;
				end else begin
					do_write = 1'b1;
					wr_addr  = ptr_inc(tail_q);
					tail_n   = ptr_inc(tail_q);
					cnt_n    = cnt_q + 1'b1;
					back_n   = cmd.value;
					if (was_empty) begin
						front_n = cmd.value;
					end
				end
			end
			KIND_POP_FRONT: begin
				if (was_empty) begin
					status_n = STATUS_EMPTY;
				end else begin
					popped_n = front_q;
					head_n   = ptr_inc(head_q);
					cnt_n    = cnt_q - 1'b1;
					// The new first entry sits one slot past the new head.
					do_read  = (cnt_q != PTR_W'(1));
					rd_addr  = ptr_inc(ptr_inc(head_q));
				end
			end
			KIND_POP_BACK: begin
				if (was_empty) begin
					status_n = STATUS_EMPTY;
				end else begin
					popped_n = back_q;
					tail_n   = ptr_dec(tail_q);
					cnt_n    = cnt_q - 1'b1;
					do_read  = (cnt_q != PTR_W'(1));
					rd_addr  = ptr_dec(tail_q);
				end
			end
			default: begin
			end
		endcase
		empty_n = (cnt_n == '0);
		cnt_ext = CNT_EXT_W'(cnt_n);
	end

	always_ff @(posedge clk) begin
		if (take && do_write) begin
			mem[wr_addr] <= cmd.value;
		end
		if (take && do_read) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				head_q      <= head_n;
				tail_q      <= tail_n;
				cnt_q       <= cnt_n;
				res_valid_q <= !do_read;
				state_q     <= do_read ? S_FETCH : S_IDLE;
			end else if (state_q == S_FETCH) begin
				res_valid_q <= 1'b1;
				state_q     <= S_IDLE;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			front_q       <= front_n;
			back_q        <= back_n;
			fetch_front_q <= (cmd.kind == KIND_POP_FRONT);
			res_popped_q  <= popped_n;
			res_status_q  <= status_n;
			res_count_q   <= cnt_ext[COUNT_W-1:0];
			res_empty_q   <= empty_n;
			res_front_q   <= empty_n ? '0 : front_n;
			res_back_q    <= empty_n ? '0 : back_n;
		end else if (state_q == S_FETCH) begin
			if (fetch_front_q) begin
				front_q     <= rd_data_q;
				res_front_q <= rd_data_q;
			end else begin
				back_q      <= rd_data_q;
				res_back_q  <= rd_data_q;
			end
		end
	end

	assign rsp.valid       = res_valid_q;
	assign rsp.popped      = res_popped_q;
	assign rsp.status      = res_status_q;
	assign rsp.count       = res_count_q;
	assign rsp.is_empty    = res_empty_q;
	assign rsp.front_value = res_front_q;
	assign rsp.back_value  = res_back_q;

endmodule

[hw/rtl/circular_deque_unit.sv]
// Top level of the circular deque: front end, command queue and execution unit.
//
// Usage: request beats arrive on the cmd channel (op, value) and each one
// produces exactly one result beat on the rsp channel (popped word, status,
// count, empty flag, front and back words), in request order.
// The front end decodes the operation and drops it into a two-entry command
// queue; the execution unit owns the ring memory, the head and tail pointers
// and cached copies of the first and last entries.
// Results: a push, a query or a refused operation shows its result in the cycle
// after the execution unit takes it from the queue; for a pop that leaves entries
// behind, the new end word is first read from the single read port of the ring
// memory into a read register and then copied into the result register. The
// execution unit therefore sustains one item per cycle for pushes and queries
// while rsp.ready stays high, and takes no new request while such a pop fetches.
// Reset clears both pointers, the count, the queue and the result valid flag;
// the ring contents are left as they are and only live slots are ever read.
// When the receiver holds rsp.ready low, the result stays in its register,
// the execution unit stops, and the queue keeps taking up to two beats.
module circular_deque_unit import cdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cdq_in_if.sink     cmd,
	cdq_out_if.source  rsp
);

	logic f_valid;
	cmd_t f_cmd;
	logic f_ready;
	logic e_valid;
	cmd_t e_cmd;
	logic e_ready;

	// Decode the request beat; the operation is held in queue form from here on.
	cdq_front u_front (
		.cmd     (cmd),
		.q_valid (f_valid),
		.q_cmd   (f_cmd),
		.q_ready (f_ready)
	);

	// The queue lets requests keep arriving while a pop waits on its memory read.
	cdq_cmd_q u_cmd_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_cmd    (f_cmd),
		.in_ready  (f_ready),
		.out_valid (e_valid),
		.out_cmd   (e_cmd),
		.out_ready (e_ready)
	);

	// All deque state lives here; full and empty checks happen at execution.
	cdq_exec #(
		.DEPTH (DEPTH)
	) u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (e_valid),
		.cmd       (e_cmd),
		.cmd_ready (e_ready),
		.rsp       (rsp)
	);

endmodule

[bench/tb_circular_deque_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench of circular_deque_unit: directed table, random traffic, predictor.
module tb_circular_deque_unit;
	import cdq_pkg::*;

	// The three codes that the block does not define. It must treat them like a query.
	localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	// Cycles without any beat on either channel before the run is declared hung.
	localparam int QUIET_LIMIT = 1000;
	// Cycles allowed after the last result for a stray beat to show up.
	localparam int DRAIN_CYCLES = 20;

	// One result beat, in the order of the rsp channel fields.
	typedef struct packed {
		logic signed [DATA_W-1:0] popped;
		logic [STATUS_W-1:0]      status;
		logic [COUNT_W-1:0]       count;
		logic                     is_empty;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] back_value;
	} deque_view_t;

	// One row of the directed table. When pinned is set, the row carries its own
	// expected result. Otherwise the predictor supplies the expected result.
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] word;
		logic              pinned;
		deque_view_t       want;
	} row_t;

	localparam deque_view_t NO_VIEW = '0;

	// The directed part starts from reset. It first tries the empty deque with a query,
	// both pops and one undefined code. It then builds up six entries with the extreme
	// words at both ends, queries them also with the other undefined codes, unwinds
	// them from both ends, pops once more on empty, and finishes with single-entry
	// round trips. Those leave the deque empty again.
	localparam int DIRECTED_LEN = 24;
	localparam row_t DIRECTED [DIRECTED_LEN] = '{
		'{OP_QUERY,      32'h0000_0000, 1'b1,
			'{32'sh0, STATUS_OK, 10'd0, 1'b1, 32'sh0, 32'sh0}},
		'{OP_POP_FRONT,  32'h1234_5678, 1'b1,
			'{32'sh0, STATUS_EMPTY, 10'd0, 1'b1, 32'sh0, 32'sh0}},
		'{OP_POP_BACK,   32'hFFFF_FFFF, 1'b1,
			'{32'sh0, STATUS_EMPTY, 10'd0, 1'b1, 32'sh0, 32'sh0}},
		'{OP_RSVD5,      32'h8000_0000, 1'b1,
			'{32'sh0, STATUS_OK, 10'd0, 1'b1, 32'sh0, 32'sh0}},
		'{OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1,
			'{32'sh0, STATUS_OK, 10'd1, 1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}},
		'{OP_PUSH_BACK,  32'h8000_0000, 1'b1,
			'{32'sh0, STATUS_OK, 10'd2, 1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000}},
		'{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1,
			'{32'sh0, STATUS_OK, 10'd3, 1'b0, 32'shFFFF_FFFF, 32'sh8000_0000}},
		'{OP_PUSH_BACK,  32'h0000_0000, 1'b0, NO_VIEW},
		'{OP_PUSH_FRONT, 32'h5555_5555, 1'b0, NO_VIEW},
		'{OP_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, NO_VIEW},
		'{OP_QUERY,      32'h0000_0000, 1'b0, NO_VIEW},
		'{OP_RSVD6,      32'hFFFF_FFFF, 1'b0, NO_VIEW},
		'{OP_RSVD7,      32'h7FFF_FFFF, 1'b0, NO_VIEW},
		'{OP_POP_BACK,   32'h0000_0000, 1'b0, NO_VIEW},
		'{OP_POP_FRONT,  32'h0000_0000, 1'b0, NO_VIEW},
		'{OP_POP_FRONT,  32'hFFFF_FFFF, 1'b0, NO_VIEW},
		'{OP_POP_BACK,   32'h0000_0000, 1'b0, NO_VIEW},
		'{OP_POP_FRONT,  32'h0000_0000, 1'b0, NO_VIEW},
		'{OP_POP_BACK,   32'h0000_0000, 1'b0, NO_VIEW},
		'{OP_POP_BACK,   32'h0000_0000, 1'b1,
			'{32'sh0, STATUS_EMPTY, 10'd0, 1'b1, 32'sh0, 32'sh0}},
		'{OP_PUSH_BACK,  32'h0000_0001, 1'b1,
			'{32'sh0, STATUS_OK, 10'd1, 1'b0, 32'sh1, 32'sh1}},
		'{OP_POP_FRONT,  32'h0000_0000, 1'b1,
			'{32'sh1, STATUS_OK, 10'd0, 1'b1, 32'sh0, 32'sh0}},
		'{OP_PUSH_FRONT, 32'h8000_0000, 1'b1,
			'{32'sh0, STATUS_OK, 10'd1, 1'b0, 32'sh8000_0000, 32'sh8000_0000}},
		'{OP_POP_BACK,   32'h0000_0000, 1'b1,
			'{32'sh8000_0000, STATUS_OK, 10'd0, 1'b1, 32'sh0, 32'sh0}}
	};

	logic clk;
	logic arst_n;

	cdq_in_if  cmd_if ();
	cdq_out_if rsp_if ();

	circular_deque_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	// This is the testbench's own copy of the deque. head_ptr points at the free slot
	// just before the first entry, and tail_ptr at the last entry. One slot always
	// stays free, so the deque is full at DEPTH_DEF-1 entries.
	logic [DATA_W-1:0] ring_copy [DEPTH_DEF];
	int unsigned       head_ptr = 0;
	int unsigned       tail_ptr = 0;

	deque_view_t pending_views [$];
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int unsigned send_idle_pct = 28;
	int unsigned take_idle_pct = 61;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned occupancy();
		return (tail_ptr + DEPTH_DEF - head_ptr) % DEPTH_DEF;
	endfunction

	// Apply one request to the testbench copy and return the result beat it must produce.
	// A push on a full deque and a pop on an empty one leave the state alone. Every
	// undefined code behaves as a query.
	function automatic deque_view_t deque_after(logic [OP_W-1:0] op, logic [DATA_W-1:0] word);
		deque_view_t v;
		int unsigned n;
		v = '0;
		n = occupancy();
		case (op)
			OP_PUSH_FRONT: begin
				if (n >= DEPTH_DEF - 1) begin
					v.status = STATUS_FULL;
				end else begin
					ring_copy[head_ptr] = word;
					head_ptr = (head_ptr + DEPTH_DEF - 1) % DEPTH_DEF;
				end
			end
			OP_PUSH_BACK: begin
				if (n >= DEPTH_DEF - 1) begin
					v.status = STATUS_FULL;
				end else begin
					tail_ptr = (tail_ptr + 1) % DEPTH_DEF;
					ring_copy[tail_ptr] = word;
				end
			end
			OP_POP_FRONT: begin
				if (n == 0) begin
					v.status = STATUS_EMPTY;
				end else begin
					head_ptr = (head_ptr + 1) % DEPTH_DEF;
					v.popped = ring_copy[head_ptr];
				end
			end
			OP_POP_BACK: begin
				if (n == 0) begin
					v.status = STATUS_EMPTY;
				end else begin
					v.popped = ring_copy[tail_ptr];
					tail_ptr = (tail_ptr + DEPTH_DEF - 1) % DEPTH_DEF;
				end
			end
			default: begin
			end
		endcase
		n = occupancy();
		v.count = n[COUNT_W-1:0];
		v.is_empty = (n == 0);
		// When the deque is empty, the front and back words must read as zero.
		if (n != 0) begin
			v.front_value = ring_copy[(head_ptr + 1) % DEPTH_DEF];
			v.back_value = ring_copy[tail_ptr];
		end
		return v;
	endfunction

	// Pick an op with the given percentages of pushes and pops. The remainder is spread
	// over all eight codes, so queries and the undefined codes turn up as well.
	function automatic logic [OP_W-1:0] pick_op(int unsigned push_pct, int unsigned pop_pct);
		int unsigned r;
		r = $urandom_range(99);
		if (r < push_pct)
			return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		if (r < push_pct + pop_pct)
			return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
		return OP_W'($urandom_range(7));
	endfunction

	// Mostly uniform words. About one in four is an extreme of the signed range, all ones or zero.
	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(15))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom();
		endcase
	endfunction

	task automatic flag(string line);
		$display("[%0t] %s", $time, line);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
		if (got !== want)
			flag($sformatf("%s: got %0h, expected %0h", name, got, want));
	endtask

	// Present one request beat, with a random number of idle cycles in front of it.
	// The sender keeps valid high from one beat to the next when it does not idle,
	// so valid is never lowered and raised again in the same time step. Once the beat
	// is taken, the expected result is queued. A pinned row queues its typed-in result.
	// The predictor still runs for a pinned row, so that its state keeps up.
	task automatic drive_beat(logic [OP_W-1:0] op, logic [DATA_W-1:0] word,
			logic pinned, deque_view_t want);
		deque_view_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.op <= op;
		cmd_if.value <= word;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
		predicted = deque_after(op, word);
		pending_views.insert(pending_views.size(), pinned ? want : predicted);
	endtask

	// Hold the sender off until every result beat that is owed has arrived.
	task automatic drain_results();
		cmd_if.valid <= 1'b0;
		while (pending_views.size() != 0)
			@(posedge clk);
	endtask

	// The receiver stalls at random, with a per-cycle chance of take_idle_pct percent.
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_if.ready <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	// Result checker. The result channel is sampled at the rising edge, before this
	// edge's updates land. Each result beat is compared field by field with the
	// oldest expectation.
	always @(posedge clk) begin
		deque_view_t got;
		deque_view_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = '{rsp_if.popped, rsp_if.status, rsp_if.count, rsp_if.is_empty,
				rsp_if.front_value, rsp_if.back_value};
			if (pending_views.size() == 0) begin
				flag("result beat arrived with no request outstanding");
			end else begin
				want = pending_views[0];
				pending_views.delete(0);
				check_field("popped", got.popped, want.popped);
				check_field("status", DATA_W'(got.status), DATA_W'(want.status));
				check_field("count", DATA_W'(got.count), DATA_W'(want.count));
				check_field("is_empty", DATA_W'(got.is_empty), DATA_W'(want.is_empty));
				check_field("front_value", got.front_value, want.front_value);
				check_field("back_value", got.back_value, want.back_value);
			end
		end
	end

	// Watchdog. Any beat on either channel restarts the count of quiet cycles. A hung
	// handshake ends the run.
	always @(posedge clk) begin
		if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] no beat for %0d cycles", $time, QUIET_LIMIT);
			$display("tb_circular_deque_unit failed");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cmd_if.valid <= 1'b0;
		cmd_if.op <= OP_QUERY;
		cmd_if.value <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. It runs with the sender idling lightly and the receiver heavily.
		for (int i = 0; i < DIRECTED_LEN; i++)
			drive_beat(DIRECTED[i].op, DIRECTED[i].word, DIRECTED[i].pinned, DIRECTED[i].want);

		// Pushes and pops are about balanced, so the deque stays shallow. It is often
		// empty, and pops on empty come up regularly.
		repeat (100)
			drive_beat(pick_op(45, 47), pick_word(), 1'b0, NO_VIEW);
		drain_results();

		// The idle rates swap sides. The traffic is mostly pushes, until the deque is full.
		send_idle_pct = 61;
		take_idle_pct = 28;
		while (occupancy() < DEPTH_DEF - 1)
			drive_beat(pick_op(95, 2), pick_word(), 1'b0, NO_VIEW);
		drain_results();

		// Neither side idles. Mixed traffic hovers at the full mark, so pushes at either
		// end are refused again and again while pops make room.
		send_idle_pct = 0;
		take_idle_pct = 0;
		repeat (60)
			drive_beat(pick_op(50, 40), pick_word(), 1'b0, NO_VIEW);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_circular_deque_unit passed");
		else
			$display("tb_circular_deque_unit failed");
		$finish;
	end

endmodule
